>>> hw/rtl/fdm_pkg.sv
// fdm_pkg: types, constants and helper functions shared by the frame difference
// motion grid block. No dependencies.
package fdm_pkg;

    localparam int MAX_WIDTH     = 512;
    localparam int MAX_HEIGHT    = 512;
    localparam int MAX_GRID_COLS = 8;
    localparam int MAX_GRID_ROWS = 7;
    localparam int NCELLS        = MAX_GRID_COLS * MAX_GRID_ROWS;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LINE_W = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = COL_W + LINE_W;
    localparam int CELL_W = $clog2(NCELLS);
    localparam int CNT_W  = 19;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // percent scale: 100 * 256 per cell
    localparam logic [14:0] PCT_SCALE = 15'd25600;
    localparam int SCALE_W = 21;
    localparam int TOTAL_W = 19;
    localparam int NUM_W   = CNT_W + SCALE_W;

    // register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_FROZEN    = 3'd1;
    localparam logic [2:0] CFG_FORMAT    = 3'd2;
    localparam logic [2:0] CFG_WIDTH     = 3'd3;
    localparam logic [2:0] CFG_HEIGHT    = 3'd4;
    localparam logic [2:0] CFG_COLS      = 3'd5;
    localparam logic [2:0] CFG_ROWS      = 3'd6;
    localparam logic [2:0] CFG_ZERO      = 3'd7;

    // pixel formats
    localparam logic [1:0] FMT_MONO = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_ARGB = 2'd2;
    localparam logic [1:0] FMT_RGBA = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_CELL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL,
        ST_CMP,
        ST_INC,
        ST_PIX,
        ST_CRD,
        ST_CMUL,
        ST_DSTART,
        ST_DIV,
        ST_COUT
    } fdm_state_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } fdm_div_status_t;

    function automatic logic [15:0] fdm_luma(input logic [1:0] fmt,
                                             input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
        logic [7:0] r, g, b;
        logic [15:0] sum;
        begin
            r = b0;
            g = b1;
            b = b2;
            if (fmt == FMT_ARGB) begin
                r = b1;
                g = b2;
                b = b3;
            end
            sum = 16'(r) * 16'd77 + 16'(g) * 16'd151 + 16'(b) * 16'd28;
            fdm_luma = (fmt == FMT_MONO) ? {b0, 8'd0} : sum;
        end
    endfunction

    // floor(x / d) for a quotient known to stay below 8
    function automatic logic [2:0] fdm_div8(input logic [12:0] x, input logic [9:0] d);
        logic [12:0] rem;
        logic [12:0] dsh;
        logic [2:0]  q;
        begin
            rem = x;
            q = 3'd0;
            for (int i = 2; i >= 0; i--) begin
                dsh = 13'(d) << i;
                if (rem >= dsh) begin
                    rem = rem - dsh;
                    q[i] = 1'b1;
                end
            end
            fdm_div8 = q;
        end
    endfunction

endpackage

>>> hw/rtl/fdm_ram.sv
// fdm_ram: generic single-write, single-read synchronous memory, registered read.
// No dependencies.
module fdm_ram #(
    parameter int AW = 6,
    parameter int DW = 19
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/fdm_div.sv
// fdm_div: bit-serial restoring divider for the cell percentages, one quotient
// bit per cycle, saturating at 65535. Depends on fdm_pkg.
module fdm_div
    import fdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [TOTAL_W-1:0]   den,
    output fdm_div_status_t      status
);

    localparam int QW = 17;

    logic [NUM_W-1:0]       rem_reg;
    logic [TOTAL_W+QW-2:0]  dsr_reg;
    logic [QW-1:0]          quo_reg;
    logic [4:0]             step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 5'(QW - 1);
                rem_reg  <= num;
                dsr_reg  <= {den, {(QW-1){1'b0}}};
                quo_reg  <= '0;
                sat_reg  <= num >= NUM_W'({den, {QW{1'b0}}});
            end else if (busy_reg) begin
                if (rem_reg >= NUM_W'(dsr_reg)) begin
                    rem_reg <= rem_reg - NUM_W'(dsr_reg);
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                dsr_reg  <= dsr_reg >> 1;
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.quo  = (sat_reg || quo_reg[QW-1]) ? 16'hFFFF : quo_reg[15:0];

endmodule

>>> hw/rtl/frame_difference_motion_grid_core.sv
// Frame difference motion grid, top level: pixel sequencer, reference luma memory,
// cell count memory and percent divider. Depends on fdm_pkg, fdm_ram, fdm_div.
//
// Pixels enter in raster order and each passes in turn through a reference luma read,
// grid cell mapping, compare and reference write, then a read-modify-write of the
// cell count in its memory, then the pixel transfer. On the last pixel of a
// frame, grid_cols*grid_rows cell results follow, each computed by the bit-serial
// percent divider at one quotient bit per cycle; the last carries tlast. The first frame
// after reset or after a change of format, width or height only loads the
// reference and reports every cell as 0. The reference memory has no reset.
module frame_difference_motion_grid_core
    import fdm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // byte_zero, byte_one, byte_two, byte_three
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_byte_zero, out_byte_one, out_byte_two, out_byte_three, cell_index, cell_percent
    output logic [55:0] m_tdata,
    // item_kind
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fdm_state_t state_reg, state_next;

    // configuration
    logic [15:0] thr_reg;
    logic        frozen_reg;
    logic [1:0]  fmt_reg;
    logic [9:0]  fw_reg, fh_reg;
    logic [3:0]  gc_reg;
    logic [2:0]  gr_reg;
    logic        zero_reg;

    logic [9:0]  w_eff, h_eff;
    logic [3:0]  gc_eff;
    logic [2:0]  gr_eff;

    // pixel datapath
    logic [7:0]        b_reg [4];
    logic [15:0]       luma_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [12:0]       cx_reg;
    logic [12:0]       ly_reg;
    logic [2:0]        c_reg, l_reg;
    logic [15:0]       old_reg;
    logic              changed_reg;
    logic [CELL_W-1:0] k_reg;
    logic [COL_W-1:0]  col_reg;
    logic [LINE_W-1:0] line_reg;
    logic              ref_valid_reg;
    logic [NCELLS-1:0] vbit_reg;
    logic              frame_end_reg;

    // readout
    logic [CELL_W-1:0]  rd_k_reg;
    logic [CELL_W-1:0]  cells_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [NUM_W-1:0]   num_reg;

    // output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    logic [15:0]       ref_rdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic [CELL_W-1:0] k_comb;
    logic [CELL_W-1:0] cnt_raddr;
    logic [CNT_W-1:0]  cnt_cur;
    logic [15:0]       diff;
    logic              out_free;
    logic              in_xfer;
    logic              cfg_xfer;
    logic              restart;
    fdm_div_status_t   div_st;

    // strobes
    logic ref_we, cnt_we, load_pix, load_cell, div_start;

    assign w_eff  = (fw_reg == 10'd0) ? 10'd1 :
                    (fw_reg > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : fw_reg;
    assign h_eff  = (fh_reg == 10'd0) ? 10'd1 :
                    (fh_reg > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : fh_reg;
    assign gc_eff = (gc_reg == 4'd0) ? 4'd1 :
                    (gc_reg > 4'(MAX_GRID_COLS)) ? 4'(MAX_GRID_COLS) : gc_reg;
    assign gr_eff = (gr_reg == 3'd0) ? 3'd1 : gr_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid;

    assign k_comb    = CELL_W'(7'(l_reg) * 7'(gc_eff) + 7'(c_reg));
    assign cnt_raddr = (state_reg == ST_CRD) ? rd_k_reg : k_comb;
    assign cnt_cur   = vbit_reg[k_reg] ? cnt_rdata : '0;
    assign diff      = (old_reg > luma_reg) ? old_reg - luma_reg : luma_reg - old_reg;

    fdm_ram #(.AW(ADDR_W), .DW(16)) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (addr_reg),
        .wdata (luma_reg),
        .raddr ({line_reg, col_reg}),
        .rdata (ref_rdata)
    );

    fdm_ram #(.AW(CELL_W), .DW(CNT_W)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (k_reg),
        .wdata (cnt_cur + CNT_W'(1)),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    fdm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (total_reg),
        .status  (div_st)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_CELL;
            ST_CELL:   state_next = ST_CMP;
            ST_CMP:    state_next = ST_INC;
            ST_INC:    state_next = ST_PIX;
            ST_PIX:    if (out_free) state_next = frame_end_reg ? ST_CRD : ST_IDLE;
            ST_CRD:    state_next = ST_CMUL;
            ST_CMUL:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (div_st.done) state_next = ST_COUT;
            ST_COUT: begin
                if (out_free) begin
                    state_next = (rd_k_reg == cells_reg - CELL_W'(1)) ? ST_IDLE : ST_CRD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ref_we    = (state_reg == ST_CMP) && (!ref_valid_reg || !frozen_reg);
        cnt_we    = (state_reg == ST_INC) && changed_reg && (cnt_cur != CNT_MAX);
        load_pix  = (state_reg == ST_PIX) && out_free;
        load_cell = (state_reg == ST_COUT) && out_free;
        div_start = (state_reg == ST_DSTART);
    end

    // configuration registers
    always_comb begin
        restart = 1'b0;
        if (cfg_xfer) begin
            unique case (cfg_index)
                CFG_FORMAT: restart = (cfg_data[1:0] != fmt_reg);
                CFG_WIDTH:  restart = (cfg_data[9:0] != fw_reg);
                CFG_HEIGHT: restart = (cfg_data[9:0] != fh_reg);
                default:    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= 16'd2560;
            frozen_reg <= 1'b0;
            fmt_reg    <= FMT_RGB;
            fw_reg     <= 10'd320;
            fh_reg     <= 10'd240;
            gc_reg     <= 4'd4;
            gr_reg     <= 3'd4;
            zero_reg   <= 1'b1;
        end else if (cfg_xfer) begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg    <= cfg_data;
                CFG_FROZEN:    frozen_reg <= cfg_data[0];
                CFG_FORMAT:    fmt_reg    <= cfg_data[1:0];
                CFG_WIDTH:     fw_reg     <= cfg_data[9:0];
                CFG_HEIGHT:    fh_reg     <= cfg_data[9:0];
                CFG_COLS:      gc_reg     <= cfg_data[3:0];
                CFG_ROWS:      gr_reg     <= cfg_data[2:0];
                CFG_ZERO:      zero_reg   <= cfg_data[0];
                default:       zero_reg   <= zero_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            line_reg      <= '0;
            ref_valid_reg <= 1'b0;
            vbit_reg      <= '0;
            frame_end_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_pix || load_cell) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cnt_we) begin
                vbit_reg[k_reg] <= 1'b1;
            end
            if (state_reg == ST_INC) begin
                frame_end_reg <= 1'b0;
                if (10'(col_reg) + 10'd1 >= w_eff) begin
                    col_reg <= '0;
                    if (10'(line_reg) + 10'd1 >= h_eff) begin
                        line_reg      <= '0;
                        frame_end_reg <= 1'b1;
                    end else begin
                        line_reg <= line_reg + LINE_W'(1);
                    end
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (load_cell && (rd_k_reg == cells_reg - CELL_W'(1))) begin
                vbit_reg      <= '0;
                ref_valid_reg <= 1'b1;
            end
            if (restart) begin
                col_reg       <= '0;
                line_reg      <= '0;
                ref_valid_reg <= 1'b0;
                vbit_reg      <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            b_reg[0] <= s_tdata[7:0];
            b_reg[1] <= s_tdata[15:8];
            b_reg[2] <= s_tdata[23:16];
            b_reg[3] <= s_tdata[31:24];
            luma_reg <= fdm_luma(fmt_reg, s_tdata[7:0], s_tdata[15:8],
                                 s_tdata[23:16], s_tdata[31:24]);
            addr_reg <= {line_reg, col_reg};
            cx_reg   <= 13'(col_reg) * 13'(gc_eff);
            ly_reg   <= 13'(line_reg) * 13'(gr_eff);
        end
        if (state_reg == ST_CELL) begin
            c_reg   <= fdm_div8(cx_reg, w_eff);
            l_reg   <= fdm_div8(ly_reg, h_eff);
            old_reg <= ref_rdata;
        end
        if (state_reg == ST_CMP) begin
            k_reg       <= k_comb;
            changed_reg <= ref_valid_reg && (diff >= thr_reg);
        end
        if (load_pix && frame_end_reg) begin
            rd_k_reg  <= '0;
            cells_reg <= CELL_W'(6'(gc_eff) * 6'(gr_eff));
            scale_reg <= SCALE_W'(6'(gc_eff) * 6'(gr_eff)) * SCALE_W'(PCT_SCALE);
            total_reg <= TOTAL_W'(w_eff) * TOTAL_W'(h_eff);
        end
        if (state_reg == ST_CMUL) begin
            k_reg   <= rd_k_reg;
            num_reg <= NUM_W'(vbit_reg[rd_k_reg] ? cnt_rdata : CNT_W'(0)) * NUM_W'(scale_reg);
        end
        if (load_cell) begin
            rd_k_reg <= rd_k_reg + CELL_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load_pix) begin
            m_tuser_reg <= KIND_PIXEL;
            m_tlast_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                if (changed_reg || !ref_valid_reg || !zero_reg) begin
                    if ((fmt_reg == FMT_MONO && i > 0) || (fmt_reg == FMT_RGB && i > 2)) begin
                        m_tdata_reg[8*i +: 8] <= 8'd0;
                    end else begin
                        m_tdata_reg[8*i +: 8] <= b_reg[i];
                    end
                end else begin
                    m_tdata_reg[8*i +: 8] <= 8'd0;
                end
            end
            m_tdata_reg[55:32] <= '0;
        end else if (load_cell) begin
            m_tuser_reg        <= KIND_CELL;
            m_tlast_reg        <= (rd_k_reg == cells_reg - CELL_W'(1));
            m_tdata_reg[31:0]  <= '0;
            m_tdata_reg[37:32] <= rd_k_reg;
            m_tdata_reg[53:38] <= div_st.quo;
            m_tdata_reg[55:54] <= '0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule
